// ===== rtl/core/dwct_pkg.sv =====
package dwct_pkg;

    localparam int DIST_W = 6;
    localparam int ID_W   = 8;
    localparam int WT_W   = 17;
    localparam int STAT_W = 2;

    localparam logic [WT_W-1:0] SUM_MAX = {WT_W{1'b1}};

    localparam logic ACT_ADD    = 1'b0;
    localparam logic ACT_SELECT = 1'b1;

    localparam logic [STAT_W-1:0] ST_SELECTED = 2'd0;
    localparam logic [STAT_W-1:0] ST_ADDED    = 2'd1;
    localparam logic [STAT_W-1:0] ST_NO_MATCH = 2'd2;
    localparam logic [STAT_W-1:0] ST_FULL     = 2'd3;

    typedef struct packed {
        logic clear;
        logic load;
        logic cnt_rd;
        logic decide;
        logic walk;
        logic out_load;
    } t_cmd;

    typedef struct packed {
        logic clear_last;
        logic is_add;
        logic add_ok;
        logic sel_start;
        logic hit;
        logic last;
        logic out_free;
    } t_stat;

endpackage

// ===== rtl/core/dwct_ram.sv =====
module dwct_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_addr,
    input  logic [WIDTH-1:0] i_wdata,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        r_rdata <= r_mem[i_addr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/core/dwct_ctrl.sv =====
module dwct_ctrl
    import dwct_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_valid,
    output logic  o_ready,
    input  t_stat i_stat,
    output t_cmd  o_cmd
);

    typedef enum logic [5:0] {
        S_CLEAR    = 6'b000001,
        S_IDLE     = 6'b000010,
        S_CNT_RD   = 6'b000100,
        S_CNT_WAIT = 6'b001000,
        S_WALK     = 6'b010000,
        S_DONE     = 6'b100000
    } t_state;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        o_ready = 1'b0;
        unique case (r_state)
            S_CLEAR: begin
                o_cmd.clear = 1'b1;
                if (i_stat.clear_last) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                o_ready = 1'b1;
                if (i_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_CNT_RD;
                end
            end
            S_CNT_RD: begin
                o_cmd.cnt_rd = 1'b1;
                n_state      = S_CNT_WAIT;
            end
            S_CNT_WAIT: begin
                o_cmd.decide = 1'b1;
                if (!i_stat.is_add && i_stat.sel_start) begin
                    n_state = S_WALK;
                end else begin
                    n_state = S_DONE;
                end
            end
            S_WALK: begin
                o_cmd.walk = 1'b1;
                if (i_stat.hit || i_stat.last) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (i_stat.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_CLEAR;
            end
        endcase
    end

endmodule

// ===== rtl/core/dwct_dp.sv =====
module dwct_dp
    import dwct_pkg::*;
#(
    parameter int DISTRICTS   = 64,
    parameter int MAX_ENTRIES = 8
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_cmd              i_cmd,
    output t_stat             o_stat,
    input  logic              i_action,
    input  logic [DIST_W-1:0] i_district,
    input  logic [ID_W-1:0]   i_choice_id,
    input  logic [WT_W-1:0]   i_weight,
    input  logic [WT_W-1:0]   i_draw,
    output logic              o_valid,
    input  logic              i_ready,
    output logic [ID_W-1:0]   o_chosen_id,
    output logic [STAT_W-1:0] o_status
);

    localparam int CNT_AW    = (DISTRICTS > 1) ? $clog2(DISTRICTS) : 1;
    localparam int CNT_W     = $clog2(MAX_ENTRIES + 1);
    localparam int ENT_DEPTH = DISTRICTS * MAX_ENTRIES;
    localparam int EA_W      = (ENT_DEPTH > 1) ? $clog2(ENT_DEPTH) : 1;
    localparam int ENT_W     = ID_W + WT_W;

    logic              r_action;
    logic [CNT_AW-1:0] r_dist_idx;
    logic [EA_W-1:0]   r_base;
    logic              r_in_range;
    logic [ID_W-1:0]   r_id;
    logic [WT_W-1:0]   r_weight;
    logic [WT_W-1:0]   r_draw;
    logic [CNT_W-1:0]  r_count;
    logic [CNT_W-1:0]  r_k;
    logic [WT_W-1:0]   r_sum;
    logic [ID_W-1:0]   r_pend_id;
    logic [STAT_W-1:0] r_pend_status;
    logic              r_out_valid;
    logic [ID_W-1:0]   r_out_id;
    logic [STAT_W-1:0] r_out_status;
    logic [CNT_AW-1:0] r_clr_idx;

    logic [31:0]       w_dist_ext;
    logic              w_cnt_we;
    logic [CNT_AW-1:0] w_cnt_addr;
    logic [CNT_W-1:0]  w_cnt_wdata;
    logic [CNT_W-1:0]  w_cnt_rdata;
    logic              w_ent_we;
    logic [EA_W-1:0]   w_ent_addr;
    logic [ENT_W-1:0]  w_ent_wdata;
    logic [ENT_W-1:0]  w_ent_rdata;
    logic [ID_W-1:0]   w_ent_id;
    logic [WT_W-1:0]   w_ent_wt;
    logic [CNT_W-1:0]  w_k_next;
    logic [WT_W:0]     w_sum_raw;
    logic [WT_W-1:0]   n_sum;

    assign w_dist_ext = 32'(i_district);

    assign o_stat.clear_last = (r_clr_idx == CNT_AW'(DISTRICTS - 1));
    assign o_stat.is_add     = (r_action == ACT_ADD);
    assign o_stat.add_ok     = r_in_range && (w_cnt_rdata < CNT_W'(MAX_ENTRIES));
    assign o_stat.sel_start  = r_in_range && (w_cnt_rdata != '0);
    assign o_stat.hit        = (r_draw <= n_sum);
    assign o_stat.last       = (w_k_next == r_count);
    assign o_stat.out_free   = !r_out_valid || i_ready;

    // per-district fill count
    assign w_cnt_we    = i_cmd.clear || (i_cmd.decide && o_stat.is_add && o_stat.add_ok);
    assign w_cnt_addr  = i_cmd.clear ? r_clr_idx : r_dist_idx;
    assign w_cnt_wdata = i_cmd.clear ? '0 : w_cnt_rdata + 1'b1;

    dwct_ram #(
        .WIDTH (CNT_W),
        .DEPTH (DISTRICTS)
    ) u_cnt_ram (
        .i_clk   (i_clk),
        .i_we    (w_cnt_we),
        .i_addr  (w_cnt_addr),
        .i_wdata (w_cnt_wdata),
        .o_rdata (w_cnt_rdata)
    );

    // entry store, one row of MAX_ENTRIES slots per district
    assign w_k_next    = r_k + 1'b1;
    assign w_ent_we    = i_cmd.decide && o_stat.is_add && o_stat.add_ok;
    assign w_ent_wdata = {r_id, r_weight};

    always_comb begin
        if (i_cmd.walk) begin
            w_ent_addr = r_base + EA_W'(w_k_next);
        end else if (o_stat.is_add) begin
            w_ent_addr = r_base + EA_W'(w_cnt_rdata);
        end else begin
            w_ent_addr = r_base;
        end
    end

    dwct_ram #(
        .WIDTH (ENT_W),
        .DEPTH (ENT_DEPTH)
    ) u_ent_ram (
        .i_clk   (i_clk),
        .i_we    (w_ent_we),
        .i_addr  (w_ent_addr),
        .i_wdata (w_ent_wdata),
        .o_rdata (w_ent_rdata)
    );

    assign w_ent_id = w_ent_rdata[ENT_W-1:WT_W];
    assign w_ent_wt = w_ent_rdata[WT_W-1:0];

    // saturating running sum
    assign w_sum_raw = {1'b0, r_sum} + {1'b0, w_ent_wt};
    assign n_sum     = w_sum_raw[WT_W] ? SUM_MAX : w_sum_raw[WT_W-1:0];

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_action   <= i_action;
            r_dist_idx <= w_dist_ext[CNT_AW-1:0];
            r_base     <= EA_W'(w_dist_ext * 32'(MAX_ENTRIES));
            r_in_range <= (w_dist_ext < 32'(DISTRICTS));
            r_id       <= i_choice_id;
            r_weight   <= i_weight;
            r_draw     <= i_draw;
        end
        if (i_cmd.decide) begin
            r_count <= w_cnt_rdata;
            r_k     <= '0;
            r_sum   <= '0;
            r_pend_id <= '0;
            if (o_stat.is_add) begin
                r_pend_status <= o_stat.add_ok ? ST_ADDED : ST_FULL;
            end else begin
                r_pend_status <= ST_NO_MATCH;
            end
        end
        if (i_cmd.walk) begin
            r_k   <= w_k_next;
            r_sum <= n_sum;
            if (o_stat.hit) begin
                r_pend_id     <= w_ent_id;
                r_pend_status <= ST_SELECTED;
            end
        end
        if (i_cmd.out_load) begin
            r_out_id     <= r_pend_id;
            r_out_status <= r_pend_status;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_clr_idx   <= '0;
        end else begin
            if (i_cmd.out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
            if (i_cmd.clear) begin
                r_clr_idx <= r_clr_idx + 1'b1;
            end
        end
    end

    assign o_valid     = r_out_valid;
    assign o_chosen_id = r_out_id;
    assign o_status    = r_out_status;

endmodule

// ===== rtl/core/district_weighted_choice_table.sv =====
// an add, or a select on an empty or unknown district, goes from accept via S_CNT_RD, S_CNT_WAIT, S_DONE
// to the output register; a select also walks k entries, 1 to MAX_ENTRIES, one entry read per cycle
// no new item is taken until the previous result has been loaded into the output register
// a finished result waits in the output register while the next beat is taken in
// reset: synchronous, active low; afterwards all DISTRICTS count memory entries are cleared in turn,
// o_ready stays low during that pass
module district_weighted_choice_table
    import dwct_pkg::*;
#(
    parameter int DISTRICTS   = 64,
    parameter int MAX_ENTRIES = 8
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  logic              i_action,
    input  logic [DIST_W-1:0] i_district,
    input  logic [ID_W-1:0]   i_choice_id,
    input  logic [WT_W-1:0]   i_weight,
    input  logic [WT_W-1:0]   i_draw,
    output logic              o_valid,
    input  logic              i_ready,
    output logic [ID_W-1:0]   o_chosen_id,
    output logic [STAT_W-1:0] o_status
);

    t_cmd  w_cmd;
    t_stat w_stat;

    dwct_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .i_stat  (w_stat),
        .o_cmd   (w_cmd)
    );

    dwct_dp #(
        .DISTRICTS   (DISTRICTS),
        .MAX_ENTRIES (MAX_ENTRIES)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_cmd),
        .o_stat      (w_stat),
        .i_action    (i_action),
        .i_district  (i_district),
        .i_choice_id (i_choice_id),
        .i_weight    (i_weight),
        .i_draw      (i_draw),
        .o_valid     (o_valid),
        .i_ready     (i_ready),
        .o_chosen_id (o_chosen_id),
        .o_status    (o_status)
    );

`ifndef SYNTHESIS
    a_id_zero_unless_selected: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_status != ST_SELECTED)) |-> (o_chosen_id == '0))
        else $error("chosen id nonzero on a result without a selection");

    a_out_load_sets_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.out_load |=> o_valid)
        else $error("result load did not raise o_valid");

    a_no_accept_in_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.clear |-> !o_ready)
        else $error("input ready during count clearing pass");

    a_no_load_while_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.out_load |-> (!o_valid || i_ready))
        else $error("result loaded over an untaken beat");
`endif

endmodule
